// ===== rtl/hfill_pkg.sv =====
// Shared types and constants for the monochrome framebuffer line-fill core.
// Used by the front end, the command queue, the back end and the top level.
package hfill_pkg;

  // Framebuffer geometry.
  localparam int ADDR_W      = 14;
  localparam int STORE_DEPTH = 16384;
  localparam int BYTE_W      = 8;
  localparam int COL_W       = 9;
  localparam int ROW_W       = 8;
  localparam int RB_W        = 7;
  localparam int BASE_W      = ROW_W + RB_W;
  localparam int BYTE_SHIFT  = 3;

  localparam logic [RB_W-1:0]       RB_RESET       = 7'd64;
  localparam logic [BYTE_W-1:0]     FULL_MASK      = 8'hFF;
  localparam logic [BYTE_SHIFT-1:0] LAST_PIX_IN_BYTE = 3'd7;

  // Request type codes carried in the input sideband.
  localparam logic REQ_DRAW = 1'b0;
  localparam logic REQ_READ = 1'b1;

  // Command queue between front and back end.
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = 1;
  localparam int Q_CNT_W = 2;

  typedef enum logic [1:0] {
    CMD_DRAW,
    CMD_READ,
    CMD_REJECT
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t             kind;
    logic [ADDR_W-1:0]     addr_first;
    logic [ADDR_W-1:0]     addr_last;
    logic [BYTE_W-1:0]     mask_first;
    logic [BYTE_W-1:0]     mask_last;
  } cmd_t;

  typedef enum logic [2:0] {
    B_CLEAR,
    B_IDLE,
    B_READ_OUT,
    B_HEAD_WR,
    B_FILL,
    B_TAIL_RD,
    B_TAIL_WR
  } back_state_t;

endpackage

// ===== rtl/hfill_front.sv =====
// Front end: accepts requests, checks draw spans and builds byte commands.
// Depends on hfill_pkg; feeds hfill_queue.
module hfill_front import hfill_pkg::*; #(
  parameter int ROWS = 256
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [39:0]           s_tdata,
  input  logic                  s_tuser,
  input  logic [RB_W-1:0]       rb,
  input  logic                  clearing,
  output logic                  push_valid,
  input  logic                  push_ready,
  output cmd_t                  push_cmd
);

  localparam int ROWS_W = $clog2(ROWS + 1);
  localparam int CMP_W  = (ROWS_W > ROW_W) ? ROWS_W : ROW_W;

  logic                  f_valid;
  logic                  f_req;
  logic [COL_W-1:0]      f_xs;
  logic [COL_W-1:0]      f_xe;
  logic                  f_ok;
  logic [BASE_W-1:0]     f_base;
  logic [RB_W-1:0]       f_rb;
  logic [ADDR_W-1:0]     f_byte_index;

  logic [COL_W-1:0]      in_xs;
  logic [COL_W-1:0]      in_xe;
  logic [ROW_W-1:0]      in_row;
  logic [ADDR_W-1:0]     in_byte_index;
  logic                  in_ok;
  logic                  accept;

  logic [BASE_W:0]       end_sum;
  logic                  fits;
  logic [ADDR_W-1:0]     addr_first;
  logic [ADDR_W-1:0]     addr_last;
  logic [BYTE_W-1:0]     mask_first;
  logic [BYTE_W-1:0]     mask_last;

  // Unpack the request fields.
  assign in_xs         = s_tdata[8:0];
  assign in_xe         = s_tdata[17:9];
  assign in_row        = s_tdata[25:18];
  assign in_byte_index = s_tdata[39:26];

  assign s_tready = !f_valid && !clearing;
  assign accept   = s_tvalid && s_tready;

  // Span checks that need only the incoming fields and the stride.
  assign in_ok = (rb != '0) && (in_xs <= in_xe) &&
                 ({1'b0, in_xe} < {rb, 3'b000}) &&
                 (CMP_W'(in_row) < CMP_W'(ROWS));

  // Holding register; the row base product is registered here.
  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (accept) begin
      f_valid <= 1'b1;
    end else if (push_valid && push_ready) begin
      f_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_req        <= s_tuser;
      f_xs         <= in_xs;
      f_xe         <= in_xe;
      f_ok         <= in_ok;
      f_base       <= {{RB_W{1'b0}}, in_row} * {{ROW_W{1'b0}}, rb};
      f_rb         <= rb;
      f_byte_index <= in_byte_index;
    end
  end

  // The row must end inside the store.
  assign end_sum = {1'b0, f_base} + {{(BASE_W + 1 - RB_W){1'b0}}, f_rb};
  assign fits    = end_sum <= (BASE_W + 1)'(STORE_DEPTH);

  // Byte addresses and edge masks of the span, most significant bit first.
  assign addr_first = f_base[ADDR_W-1:0] +
                      {{(ADDR_W - COL_W + BYTE_SHIFT){1'b0}}, f_xs[COL_W-1:BYTE_SHIFT]};
  assign addr_last  = f_base[ADDR_W-1:0] +
                      {{(ADDR_W - COL_W + BYTE_SHIFT){1'b0}}, f_xe[COL_W-1:BYTE_SHIFT]};
  assign mask_last  = FULL_MASK << (LAST_PIX_IN_BYTE - f_xe[BYTE_SHIFT-1:0]);

  always_comb begin
    mask_first = FULL_MASK >> f_xs[BYTE_SHIFT-1:0];
    // A span inside one byte uses both edge masks.
    if (f_xs[COL_W-1:BYTE_SHIFT] == f_xe[COL_W-1:BYTE_SHIFT]) begin
      mask_first = mask_first & mask_last;
    end
  end

  // Classify the request into a command for the back end.
  always_comb begin
    push_cmd.addr_first = addr_first;
    push_cmd.addr_last  = addr_last;
    push_cmd.mask_first = mask_first;
    push_cmd.mask_last  = mask_last;
    if (f_req == REQ_READ) begin
      push_cmd.kind       = CMD_READ;
      push_cmd.addr_first = f_byte_index;
    end else if (f_ok && fits) begin
      push_cmd.kind = CMD_DRAW;
    end else begin
      push_cmd.kind = CMD_REJECT;
    end
  end

  assign push_valid = f_valid;

endmodule

// ===== rtl/hfill_queue.sv =====
// Two-entry command queue between the front end and the back end.
// Depends on hfill_pkg for the command type and depth.
module hfill_queue import hfill_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push_valid,
  output logic   push_ready,
  input  cmd_t   push_cmd,
  output logic   pop_valid,
  input  logic   pop_ready,
  output cmd_t   pop_cmd
);

  cmd_t                q_mem [Q_DEPTH];
  logic [Q_PTR_W-1:0]  wr_ptr;
  logic [Q_PTR_W-1:0]  rd_ptr;
  logic [Q_CNT_W-1:0]  count;
  logic                do_push;
  logic                do_pop;

  assign push_ready = count != Q_CNT_W'(Q_DEPTH);
  assign pop_valid  = count != '0;
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_cmd    = q_mem[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      q_mem[wr_ptr] <= push_cmd;
    end
  end

endmodule

// ===== rtl/hfill_back.sv =====
// Back end: owns the framebuffer memory, clears it after reset, carries out
// reads and span fills, inner bytes one per cycle. Depends on hfill_pkg.
module hfill_back import hfill_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               pop_valid,
  output logic               pop_ready,
  input  cmd_t               pop_cmd,
  output logic               clearing,
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [BYTE_W-1:0]  m_tdata,
  output logic               m_tuser
);

  back_state_t          state;
  back_state_t          state_next;
  cmd_t                 cmd;
  logic [ADDR_W-1:0]    clr_addr;
  logic [ADDR_W-1:0]    cur;
  logic [ADDR_W-1:0]    cur_next;
  logic [BYTE_W-1:0]    mem [STORE_DEPTH];
  logic [BYTE_W-1:0]    mem_rdata;
  logic                 out_valid;
  logic [BYTE_W-1:0]    out_data;
  logic                 out_bad;

  logic                 we;
  logic [ADDR_W-1:0]    waddr;
  logic [BYTE_W-1:0]    wdata;
  logic                 re;
  logic [ADDR_W-1:0]    raddr;
  logic                 out_load;
  logic [BYTE_W-1:0]    out_data_next;
  logic                 out_bad_next;
  logic                 do_pop;

  assign clearing = state == B_CLEAR;
  assign do_pop   = pop_valid && pop_ready;

  // State, command and clear counter registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= B_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (state == B_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur <= cur_next;
    if (do_pop) begin
      cmd <= pop_cmd;
    end
  end

  // Sequencer: next state, memory port controls and result load.
  always_comb begin
    state_next    = state;
    cur_next      = cur;
    we            = 1'b0;
    waddr         = cur;
    wdata         = FULL_MASK;
    re            = 1'b0;
    raddr         = cmd.addr_last;
    out_load      = 1'b0;
    out_data_next = '0;
    out_bad_next  = 1'b0;
    pop_ready     = 1'b0;
    case (state)
      B_CLEAR: begin
        we    = 1'b1;
        waddr = clr_addr;
        wdata = '0;
        if (clr_addr == {ADDR_W{1'b1}}) begin
          state_next = B_IDLE;
        end
      end
      B_IDLE: begin
        pop_ready = !out_valid;
        if (do_pop) begin
          case (pop_cmd.kind)
            CMD_READ: begin
              re         = 1'b1;
              raddr      = pop_cmd.addr_first;
              state_next = B_READ_OUT;
            end
            CMD_DRAW: begin
              re         = 1'b1;
              raddr      = pop_cmd.addr_first;
              state_next = B_HEAD_WR;
            end
            default: begin
              out_load     = 1'b1;
              out_bad_next = 1'b1;
            end
          endcase
        end
      end
      B_READ_OUT: begin
        out_load      = 1'b1;
        out_data_next = mem_rdata;
        state_next    = B_IDLE;
      end
      B_HEAD_WR: begin
        we    = 1'b1;
        waddr = cmd.addr_first;
        wdata = mem_rdata | cmd.mask_first;
        cur_next = cmd.addr_first + 1'b1;
        if (cmd.addr_first == cmd.addr_last) begin
          out_load   = 1'b1;
          state_next = B_IDLE;
        end else if (cur_next == cmd.addr_last) begin
          state_next = B_TAIL_RD;
        end else begin
          state_next = B_FILL;
        end
      end
      B_FILL: begin
        // Whole bytes inside the span are set without a read.
        we       = 1'b1;
        waddr    = cur;
        wdata    = FULL_MASK;
        cur_next = cur + 1'b1;
        if (cur_next == cmd.addr_last) begin
          state_next = B_TAIL_RD;
        end
      end
      B_TAIL_RD: begin
        re         = 1'b1;
        raddr      = cmd.addr_last;
        state_next = B_TAIL_WR;
      end
      B_TAIL_WR: begin
        we         = 1'b1;
        waddr      = cmd.addr_last;
        wdata      = mem_rdata | cmd.mask_last;
        out_load   = 1'b1;
        state_next = B_IDLE;
      end
      default: begin
        state_next = B_IDLE;
      end
    endcase
  end

  // Framebuffer memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      mem_rdata <= mem[raddr];
    end
  end

  // Output register; a result waits here until it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data <= out_data_next;
      out_bad  <= out_bad_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;
  assign m_tuser  = out_bad;

endmodule

// ===== rtl/mono_framebuffer_hline_fill_core.sv =====
// Each request passes through the front-end holding register, the two-entry
// command queue and the back end, which runs one command at a time and fills a span
// one byte per cycle through the one memory write port, plus a read before each
// edge byte. The queue lets new requests in while the back end is busy.
// Reset (rst, synchronous): a clearing pass writes zero to all 16384 bytes,
// one per cycle; no request is accepted until it ends. row_bytes resets to 64.
module mono_framebuffer_hline_fill_core import hfill_pkg::*; #(
  parameter int MAX_ROW_BYTES = 64,
  parameter int ROWS          = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [39:0]        s_tdata,   // x_start[8:0], x_end[17:9], row[25:18],
                                        // byte_index[39:26]
  input  logic               s_tuser,   // req_type
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [BYTE_W-1:0]  m_tdata,   // read_data[7:0]
  output logic               m_tuser,   // bad_request
  input  logic               cfg_wr_en,
  input  logic [RB_W-1:0]    cfg_wr_data
);

  localparam int MRB_W = $clog2(MAX_ROW_BYTES + 1);
  localparam int CMP_W = (MRB_W > RB_W) ? MRB_W : RB_W;

  logic [RB_W-1:0]  row_bytes;
  logic [RB_W-1:0]  rb;
  logic             clearing;
  logic             push_valid;
  logic             push_ready;
  cmd_t             push_cmd;
  logic             pop_valid;
  logic             pop_ready;
  cmd_t             pop_cmd;

  // Row stride register.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_bytes <= RB_RESET;
    end else if (cfg_wr_en) begin
      row_bytes <= cfg_wr_data;
    end
  end

  // Strides above the supported maximum are clamped.
  assign rb = (CMP_W'(row_bytes) > CMP_W'(MAX_ROW_BYTES)) ? RB_W'(MAX_ROW_BYTES) : row_bytes;

  hfill_front #(
    .ROWS (ROWS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .rb         (rb),
    .clearing   (clearing),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  hfill_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  hfill_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_cmd   (pop_cmd),
    .clearing  (clearing),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

`ifndef SYNTHESIS
  // No request is taken while the memory is being cleared.
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !s_tready)
    else $error("request accepted during clearing pass");

  // No result appears while the memory is being cleared.
  a_no_result_in_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !m_tvalid)
    else $error("result presented during clearing pass");

  // A flagged request carries zero data.
  a_bad_has_zero_data: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata == '0))
    else $error("flagged result carries nonzero data");
`endif

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for the monochrome framebuffer line-fill core.
// Holds its own shadow framebuffer and row stride to predict each reply.
// Depends on rtl/hfill_pkg.sv and rtl/mono_framebuffer_hline_fill_core.sv.
module tb_top import hfill_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_ROW_BYTES = 64;
  localparam int ROWS          = 256;
  // A full-width draw plus the edge reads, with margin.
  localparam int DRAIN_CYCLES  = 2 * MAX_ROW_BYTES + 16;
  localparam int DRAIN_LIMIT   = 20000;

  // One request and one reply, as the block sees them.
  typedef struct packed {
    logic              req_type;
    logic [COL_W-1:0]  x_start;
    logic [COL_W-1:0]  x_end;
    logic [ROW_W-1:0]  row;
    logic [ADDR_W-1:0] byte_index;
  } request_t;

  typedef struct packed {
    logic [BYTE_W-1:0] read_data;
    logic              bad_request;
  } reply_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [39:0]       s_tdata = '0;   // x_start[8:0], x_end[17:9], row[25:18],
                                     // byte_index[39:26]
  logic              s_tuser = 1'b0; // req_type
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [BYTE_W-1:0] m_tdata;        // read_data[7:0]
  logic              m_tuser;        // bad_request
  logic              cfg_wr_en = 1'b0;
  logic [RB_W-1:0]   cfg_wr_data = '0;

  // Shadow copy of the framebuffer and the stride register.
  logic [BYTE_W-1:0] shadow_fb [STORE_DEPTH];
  logic [RB_W-1:0]   shadow_row_bytes = RB_RESET;
  reply_t            reply_q [$];

  bit source_gaps = 1'b1;
  bit sink_stalls = 1'b1;
  int mismatches  = 0;
  int rejects_seen = 0;

  mono_framebuffer_hline_fill_core #(
    .MAX_ROW_BYTES(MAX_ROW_BYTES),
    .ROWS(ROWS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Run limit, far above the slowest legal run including the clearing pass.
  initial begin
    #10_000_000;
    $display("FAIL mono_framebuffer_hline_fill_core");
    $finish;
  end

  // Row stride actually used: values above the maximum are clamped.
  function automatic int active_stride();
    return (shadow_row_bytes > MAX_ROW_BYTES) ? MAX_ROW_BYTES : int'(shadow_row_bytes);
  endfunction

  // Applies one request to the shadow framebuffer and returns its reply.
  function automatic reply_t predict_reply(request_t rq);
    reply_t            r;
    int                stride;
    int                base;
    int                first_b;
    int                last_b;
    logic [BYTE_W-1:0] mask;
    r = '0;
    stride = active_stride();
    if (rq.req_type == REQ_READ) begin
      r.read_data = shadow_fb[rq.byte_index];
    end else if (stride == 0 || rq.x_start > rq.x_end || rq.x_end >= stride * 8 ||
                 rq.row >= ROWS || rq.row * stride + stride > STORE_DEPTH) begin
      r.bad_request = 1'b1;
    end else begin
      base    = rq.row * stride;
      first_b = rq.x_start >> BYTE_SHIFT;
      last_b  = rq.x_end >> BYTE_SHIFT;
      for (int b = first_b; b <= last_b; b++) begin
        mask = FULL_MASK;
        if (b == first_b) mask &= FULL_MASK >> rq.x_start[2:0];
        if (b == last_b) mask &= FULL_MASK << (LAST_PIX_IN_BYTE - rq.x_end[2:0]);
        shadow_fb[(base + b) % STORE_DEPTH] |= mask;
      end
    end
    return r;
  endfunction

  function automatic request_t make_request(logic kind, int xs, int xe, int row, int idx);
    request_t rq;
    rq.req_type   = kind;
    rq.x_start    = COL_W'(xs);
    rq.x_end      = COL_W'(xe);
    rq.row        = ROW_W'(row);
    rq.byte_index = ADDR_W'(idx);
    return rq;
  endfunction

  // Mostly well-formed draws and reads of the visible screen, plus broken
  // spans and fully random noise.
  function automatic request_t random_request();
    request_t rq;
    int       stride;
    int       width_px;
    int       pick;
    int       xs;
    int       xe;
    stride   = active_stride();
    width_px = stride * 8;
    rq = make_request(REQ_DRAW, $urandom, $urandom, $urandom, $urandom);
    pick = $urandom_range(99);
    if (pick < 10) begin
      rq.req_type = 1'($urandom);
    end else if (pick < 45) begin
      rq.req_type = REQ_READ;
      if (stride != 0)
        rq.byte_index = ADDR_W'($urandom_range(ROWS - 1) * stride +
                                $urandom_range(stride - 1));
    end else if (pick < 55) begin
      if ($urandom_range(1) == 0 || width_px > 511) begin
        // Reversed span.
        xs = $urandom_range(511, 1);
        xe = $urandom_range(xs - 1, 0);
      end else begin
        // Span running past the end of the row.
        xe = $urandom_range(511, width_px);
        xs = $urandom_range(xe, 0);
      end
      rq.x_start = COL_W'(xs);
      rq.x_end   = COL_W'(xe);
    end else if (stride != 0) begin
      if ($urandom_range(31) == 0) begin
        xs = 0;
        xe = width_px - 1;
      end else begin
        xs = $urandom_range(width_px - 1);
        xe = xs + (($urandom_range(15) == 0) ? $urandom_range(width_px) : $urandom_range(23));
        if (xe > width_px - 1) xe = width_px - 1;
      end
      rq.x_start = COL_W'(xs);
      rq.x_end   = COL_W'(xe);
    end
    return rq;
  endfunction

  // Sends one request; returns at the edge where the transaction completes.
  task automatic send_request(request_t rq);
    @(negedge clk);
    if (source_gaps && $urandom_range(3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(10, 1)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {rq.byte_index, rq.row, rq.x_end, rq.x_start};
    s_tuser  <= rq.req_type;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    reply_q.insert(reply_q.size(), predict_reply(rq));
  endtask

  // Stops sending and waits until every reply is in and the block is quiet.
  task automatic wait_drained();
    int waited;
    waited = 0;
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (reply_q.size() != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_row_bytes(int value);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= RB_W'(value);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    shadow_row_bytes = RB_W'(value);
  endtask

  // The cleared store reads back as zero at both ends.
  task automatic test_reset_contents();
    send_request(make_request(REQ_READ, 511, 0, 255, 0));
    send_request(make_request(REQ_READ, 0, 511, 0, STORE_DEPTH - 1));
  endtask

  // Line shapes at the default stride of 64 bytes.
  task automatic test_draw_shapes();
    // Full-width line, with a junk read address that must be ignored.
    send_request(make_request(REQ_DRAW, 0, 511, 0, STORE_DEPTH - 1));
    send_request(make_request(REQ_READ, 0, 0, 0, 0));
    send_request(make_request(REQ_READ, 0, 0, 0, 63));
    // Span inside one byte uses both edge masks together.
    send_request(make_request(REQ_DRAW, 3, 5, 1, 0));
    send_request(make_request(REQ_READ, 0, 0, 0, 64));
    // Span across one byte boundary.
    send_request(make_request(REQ_DRAW, 6, 9, 2, 0));
    send_request(make_request(REQ_READ, 0, 0, 0, 128));
    send_request(make_request(REQ_READ, 0, 0, 0, 129));
    // Last pixel of the last row.
    send_request(make_request(REQ_DRAW, 511, 511, 255, 0));
    send_request(make_request(REQ_READ, 0, 0, 0, STORE_DEPTH - 1));
    // First pixel of a row.
    send_request(make_request(REQ_DRAW, 0, 0, 3, 0));
    send_request(make_request(REQ_READ, 0, 0, 0, 192));
    // Reversed span is rejected.
    send_request(make_request(REQ_DRAW, 10, 9, 4, 0));
  endtask

  // Stride extremes: the minimum, zero, and a value above the clamp.
  task automatic test_stride_limits();
    wait_drained();
    write_row_bytes(1);
    send_request(make_request(REQ_DRAW, 0, 7, 255, 0));
    send_request(make_request(REQ_DRAW, 0, 8, 255, 0));
    send_request(make_request(REQ_READ, 0, 0, 0, 255));
    wait_drained();
    write_row_bytes(0);
    send_request(make_request(REQ_DRAW, 0, 0, 0, 0));
    wait_drained();
    write_row_bytes(127);
    send_request(make_request(REQ_DRAW, 504, 511, 255, 0));
    send_request(make_request(REQ_READ, 0, 0, 0, STORE_DEPTH - 1));
  endtask

  // Random traffic over several strides; the last phase runs without idling.
  task automatic test_random_traffic();
    int strides [7] = '{64, 127, 1, 0, 17, 100, 0};
    int counts  [7] = '{300, 200, 150, 60, 200, 200, 250};
    int rb;
    for (int p = 0; p < 7; p++) begin
      rb = (p == 6) ? $urandom_range(126, 2) : strides[p];
      wait_drained();
      if (p == 6) begin
        source_gaps = 1'b0;
        sink_stalls = 1'b0;
      end
      write_row_bytes(rb);
      repeat (counts[p]) send_request(random_request());
    end
  endtask

  // Result side ready, with random stall bursts.
  initial begin : sink_ready
    forever begin
      @(negedge clk);
      if (sink_stalls && $urandom_range(3) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(9)) @(negedge clk);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Compares each completed result transaction with the oldest prediction.
  always @(posedge clk) begin : check_replies
    reply_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (reply_q.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected reply read_data=%02h bad_request=%0b",
                 $time, m_tdata, m_tuser);
      end else begin
        want = reply_q.pop_front();
        if (m_tdata !== want.read_data) begin
          mismatches++;
          $display("%0t: read_data expected %02h actual %02h",
                   $time, want.read_data, m_tdata);
        end
        if (m_tuser !== want.bad_request) begin
          mismatches++;
          $display("%0t: bad_request expected %0b actual %0b",
                   $time, want.bad_request, m_tuser);
        end
        if (want.bad_request) rejects_seen++;
      end
    end
  end

  // Test sequence.
  initial begin
    for (int i = 0; i < STORE_DEPTH; i++) shadow_fb[i] = '0;
    repeat (3) @(negedge clk);
    rst <= 1'b0;
    test_reset_contents();
    test_draw_shapes();
    test_stride_limits();
    test_random_traffic();
    wait_drained();
    if (reply_q.size() != 0) begin
      mismatches++;
      $display("%0t: %0d replies never arrived", $time, reply_q.size());
    end
    $display("Covered line draws at strides 0, 1, 17, 64, 100, 127 and one random stride,");
    $display("byte reads across the store, rejected spans, %0d flagged replies.",
             rejects_seen);
    if (mismatches == 0) begin
      $display("PASS mono_framebuffer_hline_fill_core");
    end else begin
      $display("FAIL mono_framebuffer_hline_fill_core");
    end
    $finish;
  end

endmodule
